/* hdl/heap_sort_engine_macros.svh */
// heap_sort_engine_macros.svh: assertion macros shared by the sort engine RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef HEAP_SORT_ENGINE_MACROS_SVH
`define HEAP_SORT_ENGINE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define HSE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define HSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/hse_pkg.sv */
// hse_pkg: types and constants of the sort engine.
// Depends on nothing; used by hse_cell and heap_sort_engine.
`timescale 1ns / 1ps

package hse_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int WORD_W       = 32;

    // Input request payload.
    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     last;
    } t_in_req;

    // Result request payload.
    typedef struct packed {
        logic signed [WORD_W-1:0] sorted_value;
        logic                     end_of_run;
        logic                     dropped;
    } t_out_req;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic                     insert;
        logic                     drain;
        logic signed [WORD_W-1:0] value;
    } t_cell_ctrl;

endpackage

/* hdl/hse_cell.sv */
// hse_cell: one slot of the sorted chain; inserts by shifting right, drains left.
// Depends on hse_pkg.
`timescale 1ns / 1ps

module hse_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  hse_pkg::t_cell_ctrl              i_ctrl,
    input  logic signed [hse_pkg::WORD_W-1:0] i_left_value,
    input  logic                             i_left_valid,
    input  logic                             i_left_gt,
    input  logic signed [hse_pkg::WORD_W-1:0] i_right_value,
    input  logic                             i_right_valid,
    output logic signed [hse_pkg::WORD_W-1:0] o_value,
    output logic                             o_valid,
    output logic                             o_gt
);

    logic signed [hse_pkg::WORD_W-1:0] r_value;
    logic signed [hse_pkg::WORD_W-1:0] n_value;
    logic                              r_valid;
    logic                              n_valid;

    // Empty slot counts as +infinity, so the valid slots stay a sorted prefix.
    assign o_gt = !r_valid || ($signed(r_value) > $signed(i_ctrl.value));

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.insert) begin
            if (o_gt) begin
                if (i_left_gt) begin
                    n_value = i_left_value;
                    n_valid = i_left_valid;
                end else begin
                    n_value = i_ctrl.value;
                    n_valid = 1'b1;
                end
            end
        end else if (i_ctrl.drain) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

/* hdl/heap_sort_engine.sv */
// heap_sort_engine: collects a set of signed values and returns it in ascending order.
// Usage notes:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one request per cycle
//   while loading. Each value is placed into a chain of CAPACITY cells kept sorted;
//   a request with last set closes the set. Values beyond CAPACITY are discarded
//   and flagged as dropped on every result of that set.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns the set smallest
//   first, end_of_run on the largest. After the last request is accepted the
//   sequencer enters its drain state, then registers the first result and raises
//   o_out_valid; then one result per cycle while the receiver is ready.
//   Loading inserts each value into the chain; draining shifts the chain left
//   once per stored value.
//   Input is not taken while the chain drains. Once the final result sits in the
//   output register the next set is taken even if that result is still stalled.
//   A receiver stall holds the output register and freezes the drain.
//   Reset (i_rst_n low, synchronous) empties the chain, clears the count, the
//   overflow flag and the output valid.
// Depends on hse_pkg, hse_cell and heap_sort_engine_macros.svh.
`timescale 1ns / 1ps
`include "heap_sort_engine_macros.svh"

module heap_sort_engine #(
    parameter int CAPACITY = hse_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hse_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hse_pkg::t_out_req o_out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    typedef enum logic {
        S_LOAD,
        S_DRAIN
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_count;    // values held in the chain
    logic                    r_overflow; // a value was dropped in this set
    logic [CNT_W-1:0]        r_remain;   // results still to drain
    logic                    r_drop_run; // dropped flag of the set being drained
    logic                    r_out_valid;
    hse_pkg::t_out_req       r_out;

    logic                    w_in_acc;
    logic                    w_has_room;
    logic                    w_out_free;
    logic                    w_drain_step;
    hse_pkg::t_cell_ctrl     w_ctrl;

    logic signed [hse_pkg::WORD_W-1:0] w_value [CAPACITY];
    logic [CAPACITY-1:0]               w_valid;
    logic [CAPACITY-1:0]               w_gt;

    assign o_in_ready   = (r_state == S_LOAD);
    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_has_room   = (r_count < CAP_CNT);
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_drain_step = (r_state == S_DRAIN) && w_out_free;

    // Every cell sees the same command; the neighbor links do the shifting.
    assign w_ctrl.insert = w_in_acc && w_has_room;
    assign w_ctrl.drain  = w_drain_step;
    assign w_ctrl.value  = i_in_data.value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [hse_pkg::WORD_W-1:0] w_lv;
        logic signed [hse_pkg::WORD_W-1:0] w_rv;
        logic                              w_lvld;
        logic                              w_lgt;
        logic                              w_rvld;

        if (g == 0) begin : g_head
            assign w_lv   = '0;
            assign w_lvld = 1'b0;
            assign w_lgt  = 1'b0;
        end else begin : g_mid_l
            assign w_lv   = w_value[g-1];
            assign w_lvld = w_valid[g-1];
            assign w_lgt  = w_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_rv   = '0;
            assign w_rvld = 1'b0;
        end else begin : g_mid_r
            assign w_rv   = w_value[g+1];
            assign w_rvld = w_valid[g+1];
        end

        hse_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_left_value (w_lv),
            .i_left_valid (w_lvld),
            .i_left_gt    (w_lgt),
            .i_right_value(w_rv),
            .i_right_valid(w_rvld),
            .o_value      (w_value[g]),
            .o_valid      (w_valid[g]),
            .o_gt         (w_gt[g])
        );
    end

    // Sequencer: loading, drain count and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_remain    <= '0;
            r_drop_run  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (i_in_data.last) begin
                            // close the set; count includes this value if stored
                            r_remain   <= w_has_room ? r_count + ONE_CNT : r_count;
                            r_drop_run <= r_overflow || !w_has_room;
                            r_count    <= '0;
                            r_overflow <= 1'b0;
                            r_state    <= S_DRAIN;
                        end else if (w_has_room) begin
                            r_count <= r_count + ONE_CNT;
                        end else begin
                            r_overflow <= 1'b1;
                        end
                    end
                end
                S_DRAIN: begin
                    if (w_drain_step) begin
                        r_remain <= r_remain - ONE_CNT;
                        if (r_remain == ONE_CNT) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase

            if (w_drain_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (w_drain_step) begin
            r_out.sorted_value <= w_value[0];
            r_out.end_of_run   <= (r_remain == ONE_CNT);
            r_out.dropped      <= r_drop_run;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks on the sequencer and the chain.
    `HSE_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CAP_CNT, "count above capacity")
    `HSE_ASSERT_ALWAYS(a_load_occupancy, i_clk, i_rst_n,
        (r_state != S_LOAD) || ($countones(w_valid) == int'(r_count)),
        "chain occupancy differs from count")
    `HSE_ASSERT_ALWAYS(a_drain_head, i_clk, i_rst_n,
        (r_state != S_DRAIN) || (w_valid[0] && (r_remain != '0)), "drain with empty chain")
    `HSE_ASSERT_ALWAYS(a_prefix, i_clk, i_rst_n, ((w_valid + 1'b1) & w_valid) == '0,
        "valid cells not a prefix")
    `HSE_ASSERT_NEXT(a_last_starts, i_clk, i_rst_n, w_in_acc && i_in_data.last,
        (r_state == S_DRAIN) && (r_count == '0), "last request did not start drain")

endmodule
